@@ rtl/numeric_literal_scanner_top_macros.svh @@
// Assertion helpers for the scanner core.
`ifndef NUMERIC_LITERAL_SCANNER_TOP_MACROS_SVH
`define NUMERIC_LITERAL_SCANNER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define NLS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define NLS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/nls_pkg.sv @@
package nls_pkg;

  // Input item
  typedef struct packed {
    logic       start_req;
    logic [7:0] current_byte;
    logic [7:0] next_byte;
    logic [7:0] after_next_byte;
    logic       text_ended;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic        literal_done;
    logic        byte_taken;
    logic        is_real;
    logic [63:0] integer_value;
    logic [63:0] fraction_mantissa;
    logic [4:0]  fraction_digits;
    logic [1:0]  error_code;
  } out_item_t;

  typedef enum logic [1:0] {
    ErrNone   = 2'd0,
    ErrDigits = 2'd1,
    ErrPoint  = 2'd2
  } err_e;

  // Byte classification handed from the decoder to the core
  typedef struct packed {
    logic [3:0] dval;       // digit value of current byte
    logic       is_dec;     // 0-9
    logic       is_hex;     // 0-9, a-f, A-F
    logic       is_under;
    logic       is_point;
    logic       is_zero;
    logic       pfx_bin;    // current byte is b/B
    logic       pfx_oct;    // current byte is o/O
    logic       pfx_hex;    // current byte is x/X
    logic       n1_prefix;  // next byte is a prefix letter
    logic       ellipsis;   // next two bytes are points
  } byte_class_t;

  // ASCII codes
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChNine   = 8'h39;
  localparam logic [7:0] ChLowA   = 8'h61;
  localparam logic [7:0] ChLowF   = 8'h66;
  localparam logic [7:0] ChUpA    = 8'h41;
  localparam logic [7:0] ChUpF    = 8'h46;
  localparam logic [7:0] ChUnder  = 8'h5F;
  localparam logic [7:0] ChPoint  = 8'h2E;
  localparam logic [7:0] ChLowB   = 8'h62;
  localparam logic [7:0] ChUpB    = 8'h42;
  localparam logic [7:0] ChLowO   = 8'h6F;
  localparam logic [7:0] ChUpO    = 8'h4F;
  localparam logic [7:0] ChLowX   = 8'h78;
  localparam logic [7:0] ChUpX    = 8'h58;

  // Digit count limits per base, saturating counter top
  localparam logic [6:0] LimBin   = 7'd64;
  localparam logic [6:0] LimOct   = 7'd22;
  localparam logic [6:0] LimHex   = 7'd16;
  localparam logic [6:0] LimDec   = 7'd20;
  localparam logic [6:0] DigitSat = 7'd127;

  // Fraction digits kept in the mantissa
  localparam logic [4:0] MaxFracDigits = 5'd19;

endpackage

@@ rtl/nls_decode.sv @@
module nls_decode import nls_pkg::*; (
  input  logic [7:0]  cur_i,
  input  logic [7:0]  n1_i,
  input  logic [7:0]  n2_i,
  output byte_class_t cls_o
);

  // Classify the current byte and the lookahead bytes
  always_comb begin
    cls_o = '0;
    if (cur_i inside {[ChZero:ChNine]}) begin
      cls_o.is_dec = 1'b1;
      cls_o.is_hex = 1'b1;
      cls_o.dval   = 4'(cur_i - ChZero);
    end else if (cur_i inside {[ChLowA:ChLowF]}) begin
      cls_o.is_hex = 1'b1;
      cls_o.dval   = 4'(cur_i - ChLowA + 8'd10);
    end else if (cur_i inside {[ChUpA:ChUpF]}) begin
      cls_o.is_hex = 1'b1;
      cls_o.dval   = 4'(cur_i - ChUpA + 8'd10);
    end
    cls_o.is_under  = (cur_i == ChUnder);
    cls_o.is_point  = (cur_i == ChPoint);
    cls_o.is_zero   = (cur_i == ChZero);
    cls_o.pfx_bin   = (cur_i == ChLowB) || (cur_i == ChUpB);
    cls_o.pfx_oct   = (cur_i == ChLowO) || (cur_i == ChUpO);
    cls_o.pfx_hex   = (cur_i == ChLowX) || (cur_i == ChUpX);
    cls_o.n1_prefix = (n1_i inside {ChLowB, ChUpB, ChLowO, ChUpO, ChLowX, ChUpX});
    cls_o.ellipsis  = (n1_i == ChPoint) && (n2_i == ChPoint);
  end

endmodule

@@ rtl/nls_core.sv @@
`include "numeric_literal_scanner_top_macros.svh"

module nls_core import nls_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        fire_i,      // registered item is processed this cycle
  input  in_item_t    item_i,
  input  byte_class_t cls_i,
  input  logic        out_stall_i,
  output logic        out_valid_o,
  output out_item_t   out_item_o
);

  typedef enum logic [6:0] {
    ModeIdle   = 7'b0000001,
    ModePrefix = 7'b0000010,
    ModeBin    = 7'b0000100,
    ModeOct    = 7'b0001000,
    ModeHex    = 7'b0010000,
    ModeDec    = 7'b0100000,
    ModeFrac   = 7'b1000000
  } mode_e;

  mode_e       mode_q, mode_d, eff_mode;
  logic [63:0] val_q, val_d, eff_val;
  logic [63:0] frac_q, frac_d, eff_frac;
  logic [4:0]  fcnt_q, fcnt_d, eff_fcnt;
  logic [6:0]  dcnt_q, dcnt_d, eff_dcnt;
  logic        pfx_start;
  logic        digit_ok;
  logic [63:0] val_acc;
  logic [6:0]  limit;
  out_item_t   res;
  out_item_t   out_q;
  logic        out_valid_q;

  // Start of a literal: clear the scan state, catch a base prefix
  always_comb begin
    eff_mode  = mode_q;
    eff_val   = val_q;
    eff_frac  = frac_q;
    eff_fcnt  = fcnt_q;
    eff_dcnt  = dcnt_q;
    pfx_start = 1'b0;
    if (item_i.start_req) begin
      eff_mode = ModeDec;
      eff_val  = '0;
      eff_frac = '0;
      eff_fcnt = '0;
      eff_dcnt = '0;
      pfx_start = !item_i.text_ended && cls_i.is_zero && cls_i.n1_prefix;
    end
  end

  // Digit check and accumulate for the active base
  always_comb begin
    digit_ok = 1'b0;
    val_acc  = eff_val;
    limit    = DigitSat;
    case (eff_mode)
      ModeBin: begin
        digit_ok = cls_i.is_dec && (cls_i.dval < 4'd2);
        val_acc  = {eff_val[62:0], 1'b0} + 64'(cls_i.dval);
        limit    = LimBin;
      end
      ModeOct: begin
        digit_ok = cls_i.is_dec && (cls_i.dval < 4'd8);
        val_acc  = {eff_val[60:0], 3'b000} + 64'(cls_i.dval);
        limit    = LimOct;
      end
      ModeHex: begin
        digit_ok = cls_i.is_hex;
        val_acc  = {eff_val[59:0], 4'b0000} + 64'(cls_i.dval);
        limit    = LimHex;
      end
      ModeDec: begin
        digit_ok = cls_i.is_dec;
        val_acc  = {eff_val[60:0], 3'b000} + {eff_val[62:0], 1'b0} + 64'(cls_i.dval);
        limit    = LimDec;
      end
      default: begin
        digit_ok = 1'b0;
      end
    endcase
  end

  // Per-mode scan step and result
  always_comb begin
    logic finish;
    logic perr;
    finish = 1'b0;
    perr   = 1'b0;
    mode_d = eff_mode;
    val_d  = eff_val;
    frac_d = eff_frac;
    fcnt_d = eff_fcnt;
    dcnt_d = eff_dcnt;
    res    = '0;

    if (pfx_start) begin
      mode_d         = ModePrefix;
      res.byte_taken = 1'b1;
    end else if (eff_mode == ModeIdle) begin
      mode_d = ModeIdle;
    end else if (item_i.text_ended) begin
      finish = 1'b1;
    end else begin
      case (eff_mode)
        ModePrefix: begin
          if (cls_i.pfx_bin) begin
            mode_d = ModeBin;
            res.byte_taken = 1'b1;
          end else if (cls_i.pfx_oct) begin
            mode_d = ModeOct;
            res.byte_taken = 1'b1;
          end else if (cls_i.pfx_hex) begin
            mode_d = ModeHex;
            res.byte_taken = 1'b1;
          end else begin
            finish = 1'b1;
          end
        end
        ModeBin, ModeOct, ModeHex, ModeDec: begin
          if (digit_ok) begin
            val_d = val_acc;
            if (eff_dcnt != DigitSat) dcnt_d = eff_dcnt + 7'd1;
            res.byte_taken = 1'b1;
          end else if (cls_i.is_under) begin
            res.byte_taken = 1'b1;
          end else if ((eff_mode == ModeDec) && cls_i.is_point && !cls_i.ellipsis) begin
            mode_d = ModeFrac;
            res.byte_taken = 1'b1;
          end else begin
            finish = 1'b1;
          end
        end
        ModeFrac: begin
          if (cls_i.is_dec) begin
            if (eff_fcnt < MaxFracDigits) begin
              frac_d = {eff_frac[60:0], 3'b000} + {eff_frac[62:0], 1'b0}
                     + 64'(cls_i.dval);
              fcnt_d = eff_fcnt + 5'd1;
            end
            res.byte_taken = 1'b1;
          end else if (cls_i.is_under) begin
            res.byte_taken = 1'b1;
          end else if (cls_i.is_point && !cls_i.ellipsis) begin
            finish = 1'b1;
            perr   = 1'b1;
          end else begin
            finish = 1'b1;
          end
        end
        default: begin
          mode_d = ModeIdle;
        end
      endcase
    end

    // Literal ends: report and return to idle
    if (finish) begin
      res.literal_done  = 1'b1;
      res.integer_value = eff_val;
      if (eff_mode == ModeFrac) begin
        res.is_real           = 1'b1;
        res.fraction_mantissa = eff_frac;
        res.fraction_digits   = eff_fcnt;
        res.error_code        = perr ? ErrPoint : ErrNone;
      end else begin
        res.error_code = (eff_dcnt > limit) ? ErrDigits : ErrNone;
      end
      mode_d = ModeIdle;
      val_d  = '0;
      frac_d = '0;
      fcnt_d = '0;
      dcnt_d = '0;
    end
  end

  // Scan state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeIdle;
      val_q  <= '0;
      frac_q <= '0;
      fcnt_q <= '0;
      dcnt_q <= '0;
    end else if (fire_i) begin
      mode_q <= mode_d;
      val_q  <= val_d;
      frac_q <= frac_d;
      fcnt_q <= fcnt_d;
      dcnt_q <= dcnt_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire_i) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // A finished literal leaves the scanner idle with cleared accumulators
  `NLS_ASSERT_NEXT(a_done_clears, fire_i && res.literal_done, (mode_q == ModeIdle) && (val_q == '0) && (dcnt_q == '0), "state not cleared after literal end")
  // Only a finished literal carries a value
  `NLS_ASSERT_NOW(a_open_zero, !res.literal_done, (res.integer_value == '0) && !res.is_real && (res.error_code == ErrNone), "payload set on open literal")
  // A real literal never reports a digit overflow
  `NLS_ASSERT_NOW(a_real_no_digit_err, res.is_real, res.error_code != ErrDigits, "digit error on real literal")
  // Fraction count is zero outside fraction mode
  `NLS_ASSERT_NOW(a_frac_bound, mode_q != ModeFrac, fcnt_q == '0, "fraction count outside fraction mode")
  // A pending result is never dropped while stalled
  `NLS_ASSERT_NEXT(a_hold_result, out_valid_q && out_stall_i, out_valid_q, "stalled result dropped")

endmodule

@@ rtl/numeric_literal_scanner_top.sv @@
// Numeric literal scanner: takes one source byte per item (with two bytes of
// lookahead) and returns one result item per input item, in order. Throughput
// is one item per clock unless a result is stalled; an item goes from the input
// register to the result register through the byte decode and the accumulate
// step (a shift-and-add by the base). The scan state lives next to the result
// register and is updated once per item, so consecutive bytes of one literal
// follow each other without a gap. There is no clearing pass after reset.
// in_stall_o rises only when a result is held by out_stall_i.
module numeric_literal_scanner_top import nls_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  logic        in_valid_q;
  in_item_t    in_q;
  logic        fire;
  byte_class_t cls;

  // Registered item moves on when the result register can take it
  assign fire       = in_valid_q && (!out_valid_o || !out_stall_i);
  assign in_stall_o = in_valid_q && !fire;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_item_i;
    end
  end

  nls_decode u_decode (
    .cur_i (in_q.current_byte),
    .n1_i  (in_q.next_byte),
    .n2_i  (in_q.after_next_byte),
    .cls_o (cls)
  );

  nls_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .item_i      (in_q),
    .cls_i       (cls),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o)
  );

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps

module tb import nls_pkg::*; ();

  localparam int unsigned NoDigit     = 255;
  localparam int unsigned WatchLimit  = 2000;
  localparam int unsigned HoldCycles  = 80;
  localparam int unsigned DrainCycles = 12;

  typedef logic [7:0] bytes_t[$];

  // Scan modes of the predictor
  typedef enum logic [2:0] {
    ModeIdle, ModePrefix, ModeBin, ModeOct, ModeHex, ModeDec, ModeFrac
  } lit_mode_e;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  // Predictor state
  lit_mode_e   lit_mode = ModeIdle;
  logic [63:0] int_acc = '0;
  logic [63:0] frac_acc = '0;
  logic [4:0]  frac_kept = '0;
  logic [6:0]  digit_seen = '0;

  out_item_t   expected_results[$];
  int unsigned fail_count = 0;
  int unsigned scan_items = 0;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  logic        hold_req = 1'b0;
  int unsigned quiet_cycles = 0;

  numeric_literal_scanner_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic void clear_scan();
    lit_mode   = ModeIdle;
    int_acc    = '0;
    frac_acc   = '0;
    frac_kept  = '0;
    digit_seen = '0;
  endfunction

  function automatic int unsigned base_of(input lit_mode_e m);
    case (m)
      ModeBin: return 2;
      ModeOct: return 8;
      ModeHex: return 16;
      default: return 10;
    endcase
  endfunction

  function automatic logic [6:0] digit_limit(input lit_mode_e m);
    case (m)
      ModeBin: return LimBin;
      ModeOct: return LimOct;
      ModeHex: return LimHex;
      ModeDec: return LimDec;
      default: return DigitSat;
    endcase
  endfunction

  function automatic int unsigned digit_value(input logic [7:0] c, input int unsigned base);
    int unsigned d;
    d = NoDigit;
    if (c >= ChZero && c <= ChNine) d = 32'(c - ChZero);
    else if (c >= ChLowA && c <= ChLowF) d = 32'(c - ChLowA) + 10;
    else if (c >= ChUpA && c <= ChUpF) d = 32'(c - ChUpA) + 10;
    return (d < base) ? d : NoDigit;
  endfunction

  function automatic lit_mode_e prefix_kind(input logic [7:0] c);
    if (c == ChLowB || c == ChUpB) return ModeBin;
    if (c == ChLowO || c == ChUpO) return ModeOct;
    if (c == ChLowX || c == ChUpX) return ModeHex;
    return ModeIdle;
  endfunction

  // Result of a literal that ends here; scan state goes back to idle
  function automatic out_item_t closed_literal(input err_e point_err);
    out_item_t r;
    r = '0;
    r.literal_done  = 1'b1;
    r.integer_value = int_acc;
    if (lit_mode == ModeFrac) begin
      r.is_real           = 1'b1;
      r.fraction_mantissa = frac_acc;
      r.fraction_digits   = frac_kept;
      r.error_code        = point_err;
    end else if (digit_seen > digit_limit(lit_mode)) begin
      r.error_code = ErrDigits;
    end
    clear_scan();
    return r;
  endfunction

  function automatic out_item_t scan_byte(input in_item_t it);
    out_item_t   r;
    logic        ellipsis;
    logic [7:0]  c;
    int unsigned base;
    int unsigned d;
    r = '0;
    c = it.current_byte;
    ellipsis = (it.next_byte == ChPoint) && (it.after_next_byte == ChPoint);
    if (it.start_req) begin
      clear_scan();
      if (!it.text_ended && c == ChZero && prefix_kind(it.next_byte) != ModeIdle) begin
        lit_mode = ModePrefix;
        r.byte_taken = 1'b1;
        return r;
      end
      lit_mode = ModeDec;
    end
    if (lit_mode == ModeIdle) return r;
    if (it.text_ended) return closed_literal(ErrNone);
    case (lit_mode)
      ModePrefix: begin
        if (prefix_kind(c) != ModeIdle) begin
          lit_mode = prefix_kind(c);
          r.byte_taken = 1'b1;
        end else begin
          r = closed_literal(ErrNone);
        end
      end
      ModeFrac: begin
        d = digit_value(c, 10);
        if (d != NoDigit) begin
          // digits past the kept count are dropped
          if (frac_kept < MaxFracDigits) begin
            frac_acc = frac_acc * 64'd10 + 64'(d);
            frac_kept++;
          end
          r.byte_taken = 1'b1;
        end else if (c == ChUnder) begin
          r.byte_taken = 1'b1;
        end else if (c == ChPoint && !ellipsis) begin
          r = closed_literal(ErrPoint);
        end else begin
          r = closed_literal(ErrNone);
        end
      end
      default: begin
        base = base_of(lit_mode);
        d = digit_value(c, base);
        if (d != NoDigit) begin
          int_acc = int_acc * 64'(base) + 64'(d);
          if (digit_seen < DigitSat) digit_seen++;
          r.byte_taken = 1'b1;
        end else if (c == ChUnder) begin
          r.byte_taken = 1'b1;
        end else if (lit_mode == ModeDec && c == ChPoint && !ellipsis) begin
          lit_mode = ModeFrac;
          r.byte_taken = 1'b1;
        end else begin
          r = closed_literal(ErrNone);
        end
      end
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------

  // Offer one item, wait for it to be taken, queue its expected result
  task automatic send_item(input in_item_t it);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    scan_items++;
    expected_results.push_back(scan_byte(it));
  endtask

  // Send a byte run; the first byte opens a literal, lookahead from the run
  task automatic send_run(input bytes_t b, input logic end_text);
    in_item_t it;
    for (int i = 0; i < b.size(); i++) begin
      it.start_req       = (i == 0);
      it.current_byte    = b[i];
      it.next_byte       = (i + 1 < b.size()) ? b[i + 1] : 8'($urandom_range(255));
      it.after_next_byte = (i + 2 < b.size()) ? b[i + 2] : 8'($urandom_range(255));
      it.text_ended      = 1'b0;
      send_item(it);
    end
    if (end_text) begin
      it.start_req       = 1'b0;
      it.current_byte    = 8'($urandom_range(255));
      it.next_byte       = 8'($urandom_range(255));
      it.after_next_byte = 8'($urandom_range(255));
      it.text_ended      = 1'b1;
      send_item(it);
    end
  endtask

  task automatic send_text(input string s, input logic end_text);
    bytes_t b;
    for (int i = 0; i < s.len(); i++) b.push_back(s[i]);
    send_run(b, end_text);
  endtask

  function automatic logic [7:0] rand_digit(input lit_mode_e m, input logic top);
    int unsigned v;
    case (m)
      ModeBin: return top ? ChZero + 8'd1 : ChZero + 8'($urandom_range(1));
      ModeOct: return top ? ChZero + 8'd7 : ChZero + 8'($urandom_range(7));
      ModeHex: begin
        v = top ? 15 : $urandom_range(21);
        if (v < 10) return ChZero + 8'(v);
        if (v < 16) return (top && $urandom_range(1)) ? ChUpF : ChLowA + 8'(v - 10);
        return ChUpA + 8'(v - 16);
      end
      default: return top ? ChNine : ChZero + 8'($urandom_range(9));
    endcase
  endfunction

  // Well-formed literal: optional prefix, digits with underscores, optional fraction
  function automatic bytes_t make_literal(input lit_mode_e m, input int unsigned ndig,
                                          input int fdig);
    bytes_t b;
    logic   top;
    int unsigned upper;
    top = ($urandom_range(99) < 5);
    upper = $urandom_range(1);
    case (m)
      ModeBin: b = '{ChZero, upper ? ChUpB : ChLowB};
      ModeOct: b = '{ChZero, upper ? ChUpO : ChLowO};
      ModeHex: b = '{ChZero, upper ? ChUpX : ChLowX};
      default: b = {};
    endcase
    for (int i = 0; i < ndig; i++) begin
      if ($urandom_range(9) == 0) b.push_back(ChUnder);
      b.push_back(rand_digit(m, top));
    end
    if (fdig >= 0) begin
      b.push_back(ChPoint);
      for (int i = 0; i < fdig; i++) begin
        if ($urandom_range(9) == 0) b.push_back(ChUnder);
        b.push_back(rand_digit(ModeDec, top));
      end
    end
    return b;
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver: random stall, or a long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin : receiver
    int unsigned held;
    held = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        held = HoldCycles;
      end
      if (held > 0) begin
        held--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < rx_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------
  task automatic check_result(input out_item_t got, input out_item_t want);
    if (got.literal_done !== want.literal_done) begin
      $error("literal_done: expected %0h, got %0h", want.literal_done, got.literal_done);
      fail_count++;
    end
    if (got.byte_taken !== want.byte_taken) begin
      $error("byte_taken: expected %0h, got %0h", want.byte_taken, got.byte_taken);
      fail_count++;
    end
    if (got.is_real !== want.is_real) begin
      $error("is_real: expected %0h, got %0h", want.is_real, got.is_real);
      fail_count++;
    end
    if (got.integer_value !== want.integer_value) begin
      $error("integer_value: expected %0h, got %0h", want.integer_value, got.integer_value);
      fail_count++;
    end
    if (got.fraction_mantissa !== want.fraction_mantissa) begin
      $error("fraction_mantissa: expected %0h, got %0h",
             want.fraction_mantissa, got.fraction_mantissa);
      fail_count++;
    end
    if (got.fraction_digits !== want.fraction_digits) begin
      $error("fraction_digits: expected %0d, got %0d",
             want.fraction_digits, got.fraction_digits);
      fail_count++;
    end
    if (got.error_code !== want.error_code) begin
      $error("error_code: expected %0h, got %0h", want.error_code, got.error_code);
      fail_count++;
    end
  endtask

  always @(posedge clk_i) begin : result_check
    out_item_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("result item with no item pending");
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        check_result(out_item, want);
      end
    end
  end

  // Watchdog: ends the run when no item moves for too long
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WatchLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Items with no literal open give an all-zero result
  task automatic test_idle_items();
    in_item_t it;
    it = '{start_req: 1'b0, current_byte: 8'hFF, next_byte: 8'h00,
           after_next_byte: 8'hFF, text_ended: 1'b0};
    send_item(it);
    it = '{start_req: 1'b0, current_byte: 8'h00, next_byte: 8'hFF,
           after_next_byte: 8'h00, text_ended: 1'b1};
    send_item(it);
  endtask

  // Prefixes, a bare prefix at end of text, a bad digit after a binary prefix
  task automatic test_prefixes();
    send_text("0x1F;", 1'b0);
    send_text("0B1", 1'b1);
    send_text("0o", 1'b1);
    send_text("0b7", 1'b0);
  endtask

  // Start at end of text and starts on bytes that are not digits
  task automatic test_odd_starts();
    in_item_t it;
    it = '{start_req: 1'b1, current_byte: ChNine, next_byte: ChLowX,
           after_next_byte: ChZero, text_ended: 1'b1};
    send_item(it);
    send_text("#", 1'b0);
    send_text("._5,", 1'b0);
    send_text("_9", 1'b1);
  endtask

  // Ellipsis in both parts, a second point, a point at the end
  task automatic test_points();
    send_text("12...", 1'b0);
    send_text("1.5.", 1'b0);
    send_text("7.", 1'b1);
    send_text("3.1...", 1'b0);
  endtask

  // A new start drops the open literal
  task automatic test_restart();
    send_text("45", 1'b0);
    send_text("9;", 1'b0);
  endtask

  // Mostly well-formed literals with random content, some noise
  task automatic random_literals(input int unsigned n);
    int unsigned goal;
    int unsigned sel;
    int unsigned lim;
    int unsigned ndig;
    int          fdig;
    lit_mode_e   m;
    bytes_t      b;
    in_item_t    it;
    goal = scan_items + n;
    while (scan_items < goal) begin
      if ($urandom_range(99) < 12) begin
        repeat ($urandom_range(4, 1)) begin
          it.start_req       = 1'($urandom_range(1));
          it.current_byte    = 8'($urandom_range(255));
          it.next_byte       = 8'($urandom_range(255));
          it.after_next_byte = 8'($urandom_range(255));
          it.text_ended      = ($urandom_range(9) == 0);
          send_item(it);
        end
      end else begin
        sel = $urandom_range(9);
        m = (sel < 2) ? ModeBin : (sel == 2) ? ModeOct : (sel < 5) ? ModeHex : ModeDec;
        lim = 32'(digit_limit(m));
        sel = $urandom_range(99);
        if (sel < 75) ndig = $urandom_range(6, 1);
        else if (sel < 96) ndig = $urandom_range(lim + 2, lim - 2);
        else ndig = $urandom_range(132, 126);
        if (m != ModeDec && $urandom_range(19) == 0) ndig = 0;
        fdig = -1;
        if (m == ModeDec && $urandom_range(99) < 40)
          fdig = ($urandom_range(99) < 85) ? $urandom_range(8) : $urandom_range(25, 17);
        b = make_literal(m, ndig, fdig);
        // how the literal ends
        sel = $urandom_range(4);
        case (sel)
          0: b.push_back(8'($urandom_range(255)));
          1: begin
            b.push_back(ChPoint);
            b.push_back(ChPoint);
            b.push_back(ChPoint);
          end
          2: begin
            b.push_back(ChPoint);
            b.push_back(rand_digit(ModeDec, 1'b0));
          end
          default: ;
        endcase
        send_run(b, sel == 3);
      end
    end
  endtask

  // Receiver holds off while the sender keeps offering a long literal
  task automatic test_output_hold();
    int unsigned saved;
    saved = tx_idle_pct;
    tx_idle_pct = 0;
    hold_req = 1'b1;
    send_run(make_literal(ModeDec, 30, 8), 1'b1);
    tx_idle_pct = saved;
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    tx_idle_pct = 35;
    rx_idle_pct = 72;
    test_idle_items();
    test_prefixes();
    test_odd_starts();
    test_points();
    test_restart();
    random_literals(450);

    tx_idle_pct = 72;
    rx_idle_pct = 35;
    random_literals(400);
    test_output_hold();
    random_literals(50);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    random_literals(450);

    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
